// File: rtl/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// types and constants shared by the confusion matrix accumulator
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int unsigned MAX_CLASSES = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_CLASSES);
  localparam int unsigned CELL_DEPTH  = MAX_CLASSES * MAX_CLASSES;
  localparam int unsigned CELL_AW     = $clog2(CELL_DEPTH);
  localparam int unsigned LABEL_WIDTH = 16;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned NCLS_W      = 5;
  localparam int unsigned PORT_LBL_W  = 16;
  localparam int unsigned PORT_CNT_W  = 32;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  localparam logic [NCLS_W-1:0] NUM_CLASSES_RST = NCLS_W'(16);

  localparam logic [APB_AW-1:0] REG_NUM_CLASSES = APB_AW'(0);

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_COUNT = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MAP_MISS = 2'd1;
  localparam logic [1:0] ST_REF_MISS = 2'd2;

  typedef struct packed {
    logic [3:0]            pad;
    logic [IDX_W-1:0]      read_col;
    logic [IDX_W-1:0]      read_row;
    logic [PORT_LBL_W-1:0] truth_cls;
    logic [PORT_LBL_W-1:0] pred_cls;
    logic [PORT_LBL_W-1:0] class_label;
    logic [IDX_W-1:0]      slot;
  } in_beat_t;

  typedef struct packed {
    logic [6:0]            pad;
    logic                  error_seen;
    logic [PORT_CNT_W-1:0] grand_total;
    logic [PORT_CNT_W-1:0] diag_total;
    logic [PORT_CNT_W-1:0] col_total;
    logic [PORT_CNT_W-1:0] row_total;
    logic [PORT_CNT_W-1:0] cell_count;
    logic [IDX_W-1:0]      ref_index;
    logic [IDX_W-1:0]      map_index;
  } out_beat_t;

  localparam int unsigned IN_DW  = $bits(in_beat_t);
  localparam int unsigned OUT_DW = $bits(out_beat_t);

endpackage

// File: rtl/confusion_matrix_accumulator_top.sv
// ----------------------------------------------------------------------------
// confusion_matrix_accumulator_top
// confusion matrix accumulator with class id table and running totals
// ----------------------------------------------------------------------------
// input beats arrive on the s_axis channel, tuser holds the function:
// load a class id into a slot, count one (map, reference) label pair, or read
// one cell with its row and column totals. every input beat gives exactly one
// result beat on m_axis, status in tuser.
// the cell counts live in a ram with a registered read. a beat is looked
// up and issues its cell read in the cycle it is accepted, stage 1 then
// does the saturating increment and the write back, with forwarding from the
// previous write to the same cell, and the result lands in the output
// register. one beat per cycle is sustained while the receiver takes results.
// when m_axis stalls the output register and the stage in front of it hold,
// and s_axis_tready drops once both are full.
// reset clears the class ids, the totals, the error flag and a valid bit per
// cell, so the matrix reads as zero right away. num_classes resets to 16. the
// user must write it over apb only while the block is idle; no logic checks it.
// ----------------------------------------------------------------------------
module confusion_matrix_accumulator_top #(
  parameter int unsigned LABEL_WIDTH = cma_pkg::LABEL_WIDTH,
  parameter int unsigned COUNT_WIDTH = cma_pkg::COUNT_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cma_pkg::APB_AW-1:0]    paddr,
  input  logic [cma_pkg::APB_DW-1:0]    pwdata,
  output logic [cma_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // slot, class_label, pred_cls, truth_cls, read_row, read_col
  input  logic [cma_pkg::IN_DW-1:0]     s_axis_tdata,
  // func
  input  logic [1:0]                    s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // map_index, ref_index, cell_count, row_total, col_total, diag_total,
  // grand_total, error_seen
  output logic [cma_pkg::OUT_DW-1:0]    m_axis_tdata,
  // status
  output logic [1:0]                    m_axis_tuser
);

  import cma_pkg::*;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == {COUNT_WIDTH{1'b1}}) ? c : c + COUNT_WIDTH'(1);
  endfunction

  // configuration
  logic [NCLS_W-1:0] num_classes_q;
  logic              cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_classes_q <= NUM_CLASSES_RST;
    end else if (cfg_wr && paddr == REG_NUM_CLASSES) begin
      num_classes_q <= pwdata[NCLS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_NUM_CLASSES) begin
      prdata = APB_DW'(num_classes_q);
    end
  end

  // stage 0: accept, lookup, cell read
  in_beat_t          beat;
  func_e             fn;
  logic              in_acc;
  logic              s1_adv;
  logic              s1_valid_q;
  logic              out_valid_q;

  logic [LABEL_WIDTH-1:0] class_id_q [MAX_CLASSES];
  logic [LABEL_WIDTH-1:0] map_lbl, ref_lbl;
  logic [IDX_W-1:0]       map_idx, ref_idx;
  logic                   map_hit, ref_hit;

  logic [1:0]        st_d;
  logic [IDX_W-1:0]  mi_d, ri_d;
  logic              rd_en;
  logic [CELL_AW-1:0] rd_addr;

  assign beat          = in_beat_t'(s_axis_tdata);
  assign fn            = func_e'(s_axis_tuser);
  assign s1_adv        = s1_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | s1_adv;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign map_lbl       = LABEL_WIDTH'(beat.pred_cls);
  assign ref_lbl       = LABEL_WIDTH'(beat.truth_cls);

  always_comb begin
    map_hit = 1'b0;
    ref_hit = 1'b0;
    map_idx = '0;
    ref_idx = '0;
    for (int k = MAX_CLASSES - 1; k >= 0; k--) begin
      if (NCLS_W'(k) < num_classes_q && class_id_q[k] == map_lbl) begin
        map_hit = 1'b1;
        map_idx = IDX_W'(k);
      end
      if (NCLS_W'(k) < num_classes_q && class_id_q[k] == ref_lbl) begin
        ref_hit = 1'b1;
        ref_idx = IDX_W'(k);
      end
    end
  end

  always_comb begin
    st_d    = ST_OK;
    mi_d    = '0;
    ri_d    = '0;
    rd_en   = 1'b0;
    unique case (fn)
      FUNC_LOAD: begin
        mi_d = beat.slot;
      end
      FUNC_COUNT: begin
        st_d  = (map_hit ? ST_OK : ST_MAP_MISS) | (ref_hit ? ST_OK : ST_REF_MISS);
        mi_d  = map_idx;
        ri_d  = ref_idx;
        rd_en = in_acc;
      end
      FUNC_READ: begin
        mi_d  = beat.read_row;
        ri_d  = beat.read_col;
        rd_en = in_acc;
      end
      default: begin
      end
    endcase
    rd_addr = {mi_d, ri_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_CLASSES; k++) begin
        class_id_q[k] <= '0;
      end
    end else if (in_acc && fn == FUNC_LOAD) begin
      class_id_q[beat.slot] <= LABEL_WIDTH'(beat.class_label);
    end
  end

  // stage 1: modify and write back
  logic [1:0]             s1_func_q;
  logic [1:0]             s1_st_q;
  logic [IDX_W-1:0]       s1_mi_q, s1_ri_q;
  logic                   fwd_hit_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;
  logic                   cell_vld_q;
  logic [CELL_DEPTH-1:0]  vld_q;

  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] cell_old, cell_new;
  logic [CELL_AW-1:0]     wr_addr;
  logic                   wr_en;

  logic [COUNT_WIDTH-1:0] row_sum_q [MAX_CLASSES];
  logic [COUNT_WIDTH-1:0] col_sum_q [MAX_CLASSES];
  logic [COUNT_WIDTH-1:0] diag_q, diag_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;
  logic                   err_q, err_d;
  logic [COUNT_WIDTH-1:0] row_new, col_new;
  out_beat_t              res;
  logic                   is_count_ok;

  cma_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (CELL_DEPTH)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (cell_new),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign is_count_ok = (s1_func_q == FUNC_COUNT) && (s1_st_q == ST_OK);
  assign wr_addr     = {s1_mi_q, s1_ri_q};
  assign wr_en       = s1_adv & is_count_ok;
  assign cell_old    = fwd_hit_q ? fwd_data_q : (cell_vld_q ? ram_rdata : '0);
  assign cell_new    = sat_inc(cell_old);
  assign row_new     = sat_inc(row_sum_q[s1_mi_q]);
  assign col_new     = sat_inc(col_sum_q[s1_ri_q]);

  always_comb begin
    diag_d = diag_q;
    total_d = total_q;
    err_d = err_q;
    res = '0;
    res.map_index = s1_mi_q;
    res.ref_index = s1_ri_q;
    case (s1_func_q)
      FUNC_COUNT: begin
        if (s1_st_q == ST_OK) begin
          total_d = sat_inc(total_q);
          if (s1_mi_q == s1_ri_q) begin
            diag_d = sat_inc(diag_q);
          end
          res.cell_count = PORT_CNT_W'(cell_new);
          res.row_total  = PORT_CNT_W'(row_new);
          res.col_total  = PORT_CNT_W'(col_new);
        end else begin
          err_d = 1'b1;
        end
      end
      FUNC_READ: begin
        res.cell_count = PORT_CNT_W'(cell_old);
        res.row_total  = PORT_CNT_W'(row_sum_q[s1_mi_q]);
        res.col_total  = PORT_CNT_W'(col_sum_q[s1_ri_q]);
      end
      default: begin
      end
    endcase
    res.diag_total  = PORT_CNT_W'(diag_d);
    res.grand_total = PORT_CNT_W'(total_d);
    res.error_seen  = err_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q  <= s_axis_tuser;
      s1_st_q    <= st_d;
      s1_mi_q    <= mi_d;
      s1_ri_q    <= ri_d;
      fwd_hit_q  <= wr_en && (wr_addr == rd_addr);
      fwd_data_q <= cell_new;
      cell_vld_q <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      vld_q      <= '0;
      diag_q     <= '0;
      total_q    <= '0;
      err_q      <= 1'b0;
      for (int k = 0; k < MAX_CLASSES; k++) begin
        row_sum_q[k] <= '0;
        col_sum_q[k] <= '0;
      end
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        diag_q  <= diag_d;
        total_q <= total_d;
        err_q   <= err_d;
      end
      if (wr_en) begin
        vld_q[wr_addr]     <= 1'b1;
        row_sum_q[s1_mi_q] <= row_new;
        col_sum_q[s1_ri_q] <= col_new;
      end
    end
  end

  // output register
  out_beat_t  out_q;
  logic [1:0] out_st_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q    <= res;
      out_st_q <= s1_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = out_st_q;

endmodule

// File: rtl/cma_ram.sv
// ----------------------------------------------------------------------------
// cma_ram
// simple dual port ram, one write and one read port, registered read
// ----------------------------------------------------------------------------
module cma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the confusion matrix accumulator
// ----------------------------------------------------------------------------
// a short directed part runs first: state after reset, class id loads with
// a duplicate id, pairs that match, miss one label or miss both, cell reads,
// the unused function code, and the num_classes setting at 0, 1, 16 and 31.
// a random part follows over several num_classes settings. it loads ids,
// counts pairs whose labels mostly come from the active slots, and reads
// cells. a shadow copy of the id table and the counters predicts every
// result beat, and the beats are checked in order. both streams idle at
// random, except during one phase where they run without gaps.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cma_pkg::*;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PRINT_LIMIT = 30;
  localparam int unsigned RANDOM_BEATS = 950;

  typedef struct packed {
    logic [1:0] status;
    out_beat_t  beat;
  } outcome_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // slot, class_label, pred_cls, truth_cls, read_row, read_col
  logic [IN_DW-1:0]   s_axis_tdata = '0;
  // func
  logic [1:0]         s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // map_index, ref_index, cell_count, row_total, col_total, diag_total,
  // grand_total, error_seen
  logic [OUT_DW-1:0]  m_axis_tdata;
  // status
  logic [1:0]         m_axis_tuser;

  // shadow of the block state
  logic [LABEL_WIDTH-1:0] id_table [MAX_CLASSES];
  logic [COUNT_WIDTH-1:0] cell_tab [MAX_CLASSES][MAX_CLASSES];
  logic [COUNT_WIDTH-1:0] row_acc [MAX_CLASSES];
  logic [COUNT_WIDTH-1:0] col_acc [MAX_CLASSES];
  logic [COUNT_WIDTH-1:0] diag_acc;
  logic [COUNT_WIDTH-1:0] pair_acc;
  logic                   err_sticky;
  logic [NCLS_W-1:0]      ncls_shadow;

  outcome_t    outcome_q [$];
  outcome_t    head_outcome;
  out_beat_t   seen_beat;
  bit          steady_flow = 1'b0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned beats_loaded = 0;
  int unsigned pairs_counted = 0;
  int unsigned pairs_missed = 0;
  int unsigned cells_read = 0;
  int unsigned unused_beats = 0;
  int unsigned settings_used = 0;

  confusion_matrix_accumulator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned active_slots();
    return (32'(ncls_shadow) > MAX_CLASSES) ? MAX_CLASSES : 32'(ncls_shadow);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + COUNT_WIDTH'(1);
  endfunction

  // lowest active slot holding the label
  function automatic bit find_slot(input logic [LABEL_WIDTH-1:0] lbl,
                                   output logic [IDX_W-1:0] idx);
    bit hit;
    hit = 1'b0;
    idx = '0;
    for (int k = 0; k < MAX_CLASSES; k++) begin
      if (k < active_slots() && !hit && id_table[k] == lbl) begin
        hit = 1'b1;
        idx = IDX_W'(k);
      end
    end
    return hit;
  endfunction

  function automatic outcome_t matrix_outcome(logic [1:0] fn, in_beat_t b);
    outcome_t o;
    logic [IDX_W-1:0] mi, ri;
    bit mhit, rhit;
    o = '0;
    case (fn)
      FUNC_LOAD: begin
        id_table[b.slot] = b.class_label;
        o.beat.map_index = b.slot;
      end
      FUNC_COUNT: begin
        mhit = find_slot(b.pred_cls, mi);
        rhit = find_slot(b.truth_cls, ri);
        if (!mhit) o.status |= ST_MAP_MISS;
        if (!rhit) o.status |= ST_REF_MISS;
        if (mhit) o.beat.map_index = mi;
        if (rhit) o.beat.ref_index = ri;
        if (mhit && rhit) begin
          cell_tab[mi][ri] = sat_inc(cell_tab[mi][ri]);
          row_acc[mi] = sat_inc(row_acc[mi]);
          col_acc[ri] = sat_inc(col_acc[ri]);
          pair_acc = sat_inc(pair_acc);
          if (mi == ri) diag_acc = sat_inc(diag_acc);
          o.beat.cell_count = cell_tab[mi][ri];
          o.beat.row_total = row_acc[mi];
          o.beat.col_total = col_acc[ri];
        end else begin
          err_sticky = 1'b1;
        end
      end
      FUNC_READ: begin
        o.beat.map_index = b.read_row;
        o.beat.ref_index = b.read_col;
        o.beat.cell_count = cell_tab[b.read_row][b.read_col];
        o.beat.row_total = row_acc[b.read_row];
        o.beat.col_total = col_acc[b.read_col];
      end
      default: ;
    endcase
    o.beat.diag_total = diag_acc;
    o.beat.grand_total = pair_acc;
    o.beat.error_seen = err_sticky;
    return o;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.pad = '0;
    b.slot = IDX_W'($urandom);
    b.class_label = PORT_LBL_W'($urandom);
    b.pred_cls = PORT_LBL_W'($urandom);
    b.truth_cls = PORT_LBL_W'($urandom);
    b.read_row = IDX_W'($urandom);
    b.read_col = IDX_W'($urandom);
    return b;
  endfunction

  // mostly a label of an active slot, else an inactive slot or noise
  function automatic logic [LABEL_WIDTH-1:0] pick_label();
    int unsigned eff, r;
    eff = active_slots();
    r = $urandom_range(99);
    if (eff > 0 && r < 85) return id_table[$urandom_range(eff - 1)];
    if (eff < MAX_CLASSES && r < 92) return id_table[$urandom_range(MAX_CLASSES - 1, eff)];
    return LABEL_WIDTH'($urandom);
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  task automatic push_beat(logic [1:0] fn, in_beat_t b);
    outcome_t o;
    if (!steady_flow && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    o = matrix_outcome(fn, b);
    outcome_q.push_back(o);
    case (fn)
      FUNC_LOAD: beats_loaded++;
      FUNC_COUNT: if (o.status == ST_OK) pairs_counted++; else pairs_missed++;
      FUNC_READ: cells_read++;
      default: unused_beats++;
    endcase
  endtask

  task automatic settle_stream();
    s_axis_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_num_classes(logic [NCLS_W-1:0] n);
    settle_stream();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_NUM_CLASSES;
    pwdata <= APB_DW'(n);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    ncls_shadow = n;
    settings_used++;
  endtask

  task automatic send_pair(logic [LABEL_WIDTH-1:0] m, logic [LABEL_WIDTH-1:0] r);
    in_beat_t b;
    b = random_beat();
    b.pred_cls = m;
    b.truth_cls = r;
    push_beat(FUNC_COUNT, b);
  endtask

  task automatic send_load(logic [IDX_W-1:0] s, logic [LABEL_WIDTH-1:0] lbl);
    in_beat_t b;
    b = random_beat();
    b.slot = s;
    b.class_label = lbl;
    push_beat(FUNC_LOAD, b);
  endtask

  task automatic send_read(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
    in_beat_t b;
    b = random_beat();
    b.read_row = row;
    b.read_col = col;
    push_beat(FUNC_READ, b);
  endtask

  task automatic test_reset_state();
    send_pair(16'h0000, 16'h0000);
    send_read(4'd0, 4'd0);
    send_read(4'd15, 4'd15);
    push_beat(FUNC_UNUSED, '{pad: '0, default: '1});
  endtask

  task automatic test_class_table();
    send_load(4'd0, 16'hFFFF);
    send_load(4'd1, 16'h1234);
    send_load(4'd2, 16'h1234);
    send_load(4'd15, 16'hA5A5);
    send_load(4'd7, 16'h5A5A);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h1234, 16'hA5A5);
    send_pair(16'hA5A5, 16'h1234);
    send_pair(16'h5A5A, 16'hBEEF);
    send_pair(16'hBEEF, 16'hFFFF);
    send_pair(16'hBEEF, 16'hCAFE);
    send_read(4'd1, 4'd15);
    send_read(4'd15, 4'd1);
    send_read(4'd0, 4'd0);
  endtask

  task automatic test_active_classes();
    write_num_classes(5'd0);
    send_pair(16'hFFFF, 16'hFFFF);
    write_num_classes(5'd1);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'hFFFF, 16'h1234);
    write_num_classes(5'd31);
    send_pair(16'hA5A5, 16'hA5A5);
    write_num_classes(5'd16);
  endtask

  task automatic test_random_stream();
    logic [NCLS_W-1:0] settings [8];
    in_beat_t b;
    int unsigned useful, quota, r;
    settings = '{5'd16, 5'd7, 5'd1, 5'd31, 5'd0, 5'd12, 5'd2, 5'd16};
    quota = RANDOM_BEATS / 8;
    for (int p = 0; p < 8; p++) begin
      write_num_classes(settings[p]);
      steady_flow = (p == 3);
      useful = 0;
      while (useful < quota) begin
        b = random_beat();
        r = $urandom_range(99);
        if (r < 10) begin
          if ($urandom_range(4) == 0) b.class_label = id_table[$urandom_range(MAX_CLASSES - 1)];
          push_beat(FUNC_LOAD, b);
          useful++;
        end else if (r < 75) begin
          b.pred_cls = pick_label();
          b.truth_cls = pick_label();
          push_beat(FUNC_COUNT, b);
          useful++;
        end else if (r < 96) begin
          push_beat(FUNC_READ, b);
          useful++;
        end else begin
          push_beat(FUNC_UNUSED, b);
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 33);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_beat = out_beat_t'(m_axis_tdata);
      if (outcome_q.size() == 0) begin
        flag_mismatch("unexpected result beat", 32'(m_axis_tuser), 32'd0);
      end else begin
        head_outcome = outcome_q.pop_front();
        if (m_axis_tuser != head_outcome.status)
          flag_mismatch("status", 32'(m_axis_tuser), 32'(head_outcome.status));
        if (seen_beat.map_index != head_outcome.beat.map_index)
          flag_mismatch("map_index", 32'(seen_beat.map_index),
                        32'(head_outcome.beat.map_index));
        if (seen_beat.ref_index != head_outcome.beat.ref_index)
          flag_mismatch("ref_index", 32'(seen_beat.ref_index),
                        32'(head_outcome.beat.ref_index));
        if (seen_beat.cell_count != head_outcome.beat.cell_count)
          flag_mismatch("cell_count", seen_beat.cell_count, head_outcome.beat.cell_count);
        if (seen_beat.row_total != head_outcome.beat.row_total)
          flag_mismatch("row_total", seen_beat.row_total, head_outcome.beat.row_total);
        if (seen_beat.col_total != head_outcome.beat.col_total)
          flag_mismatch("col_total", seen_beat.col_total, head_outcome.beat.col_total);
        if (seen_beat.diag_total != head_outcome.beat.diag_total)
          flag_mismatch("diag_total", seen_beat.diag_total, head_outcome.beat.diag_total);
        if (seen_beat.grand_total != head_outcome.beat.grand_total)
          flag_mismatch("grand_total", seen_beat.grand_total, head_outcome.beat.grand_total);
        if (seen_beat.error_seen != head_outcome.beat.error_seen)
          flag_mismatch("error_seen", 32'(seen_beat.error_seen),
                        32'(head_outcome.beat.error_seen));
      end
    end
  end

  // no beat accepted on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_CLASSES; i++) begin
      id_table[i] = '0;
      row_acc[i] = '0;
      col_acc[i] = '0;
      for (int j = 0; j < MAX_CLASSES; j++) cell_tab[i][j] = '0;
    end
    diag_acc = '0;
    pair_acc = '0;
    err_sticky = 1'b0;
    ncls_shadow = NUM_CLASSES_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_class_table();
    test_active_classes();
    test_random_stream();
    settle_stream();
    repeat (4) @(posedge clk_i);
    if (outcome_q.size() != 0)
      flag_mismatch("results never returned", outcome_q.size(), 32'd0);
    $display("covered %0d loads, %0d counted pairs, %0d pairs with unknown labels,",
             beats_loaded, pairs_counted, pairs_missed);
    $display("%0d cell reads, %0d unused-code beats over %0d num_classes writes",
             cells_read, unused_beats, settings_used);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cma_pkg.sv
rtl/cma_ram.sv
rtl/confusion_matrix_accumulator_top.sv
verif/testbench.sv
